>>> rtl/core/rhse_pkg.sv
`timescale 1ns / 1ps

package rhse_pkg;

   localparam int unsigned MAX_LEN = 4096;
   localparam int unsigned POS_W   = 13;
   localparam int unsigned HASH_W  = 61;
   localparam int unsigned BASE_W  = 32;

   localparam logic [HASH_W-1:0] MOD61 = {HASH_W{1'b1}};
   localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(131);

   localparam logic [1:0] FUNC_APPEND = 2'd0;
   localparam logic [1:0] FUNC_HASH   = 2'd1;
   localparam logic [1:0] FUNC_LCP    = 2'd2;
   localparam logic [1:0] FUNC_CLEAR  = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_APP_RD,
      S_APP_MUL1,
      S_APP_W1,
      S_APP_W2,
      S_RH_RD1,
      S_RH_RD2,
      S_RH_MUL,
      S_RH_WAIT,
      S_LCP_CHK
   } state_type;

   function automatic logic [HASH_W-1:0] mod_add(input logic [HASH_W-1:0] a,
                                                 input logic [HASH_W-1:0] b);
      logic [HASH_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, MOD61}) begin
         s = s - {1'b0, MOD61};
      end
      return s[HASH_W-1:0];
   endfunction

   function automatic logic [HASH_W-1:0] mod_sub(input logic [HASH_W-1:0] a,
                                                 input logic [HASH_W-1:0] b);
      logic [HASH_W:0] s;
      s = {1'b0, a} + {1'b0, MOD61 - b};
      if (s >= {1'b0, MOD61}) begin
         s = s - {1'b0, MOD61};
      end
      return s[HASH_W-1:0];
   endfunction

endpackage

>>> rtl/core/rhse_mulmod.sv
`timescale 1ns / 1ps

module rhse_mulmod
   import rhse_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [HASH_W-1:0] op_a,
   input  logic [HASH_W-1:0] op_b,
   output logic              done,
   output logic [HASH_W-1:0] product
);

   localparam int unsigned ACC_W = 2 * HASH_W;

   logic [HASH_W-1:0] a_ff, b_ff;
   logic              run_ff;
   logic [2:0]        phase_ff;
   logic [63:0]       pp_ff;
   logic [1:0]        pp_sel_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic [HASH_W:0]   f1_ff;
   logic [HASH_W-1:0] product_ff;
   logic              done_ff;

   logic [31:0]       mx, my;
   logic [63:0]       pp_in;
   logic [ACC_W-1:0]  addend;
   logic [HASH_W:0]   f2;

   always_comb begin
      case (phase_ff[1:0])
         2'd0: begin
            mx = a_ff[31:0];
            my = b_ff[31:0];
         end
         2'd1: begin
            mx = a_ff[31:0];
            my = {3'b0, b_ff[HASH_W-1:32]};
         end
         2'd2: begin
            mx = {3'b0, a_ff[HASH_W-1:32]};
            my = b_ff[31:0];
         end
         default: begin
            mx = {3'b0, a_ff[HASH_W-1:32]};
            my = {3'b0, b_ff[HASH_W-1:32]};
         end
      endcase
      pp_in = mx * my;

      case (pp_sel_ff)
         2'd0:    addend = {58'b0, pp_ff};
         2'd1,
         2'd2:    addend = {29'b0, pp_ff[60:0], 32'b0};
         default: addend = {pp_ff[57:0], 64'b0};
      endcase

      f2 = {1'b0, f1_ff[HASH_W-1:0]} + {{HASH_W{1'b0}}, f1_ff[HASH_W]};
      if (f2 >= {1'b0, MOD61}) begin
         f2 = f2 - {1'b0, MOD61};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= 3'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff   <= 1'b1;
            phase_ff <= 3'd0;
         end else if (run_ff) begin
            phase_ff <= phase_ff + 3'd1;
            if (phase_ff == 3'd6) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= op_a;
         b_ff   <= op_b;
         acc_ff <= '0;
      end else if (run_ff) begin
         if (phase_ff <= 3'd3) begin
            pp_ff     <= pp_in;
            pp_sel_ff <= phase_ff[1:0];
         end
         if (phase_ff >= 3'd1 && phase_ff <= 3'd4) begin
            acc_ff <= acc_ff + addend;
         end
         if (phase_ff == 3'd5) begin
            f1_ff <= {1'b0, acc_ff[HASH_W-1:0]} + {1'b0, acc_ff[ACC_W-1:HASH_W]};
         end
         if (phase_ff == 3'd6) begin
            product_ff <= f2[HASH_W-1:0];
         end
      end
   end

   assign done    = done_ff;
   assign product = product_ff;

endmodule

>>> rtl/core/rolling_hash_substring_engine.sv
`timescale 1ns / 1ps
// Rolling hash substring engine: polynomial hash mod 2^61-1 over a byte text.
// Request: drive req_* with start high; the request is taken on an edge where
// busy is low. Functions: append a byte, hash of [left, right), longest common
// prefix of the suffixes at left and right, clear.
// Result: one per request, shown for one cycle with rsp_strobe. The receiver
// cannot stall; the result is simply taken on that cycle.
// csr_* writes the 32-bit base; csr_ready is always high. Write only when idle.
// Clear and rejected requests are answered without leaving idle; common prefix
// takes up to 13 binary-search rounds. One request at a time: busy stays high
// until its result is out.
// Rate is set by the modular multiplier, one 32x32 partial product per cycle,
// then an accumulate and two fold steps, and by one read port on each of the
// two tables (prefix hashes and base powers, 4097 entries each).
// Reset: text length 0, base 131. Table entry zero is fixed (hash 0, power 1);
// other entries need no clearing since only written entries are ever read.

module rolling_hash_substring_engine
   import rhse_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_func,
   input  logic [7:0]        req_char_value,
   input  logic [POS_W-1:0]  req_left_pos,
   input  logic [POS_W-1:0]  req_right_pos,
   output logic              rsp_strobe,
   output logic [HASH_W-1:0] rsp_hash_value,
   output logic [POS_W-1:0]  rsp_prefix_length,
   output logic [1:0]        rsp_status,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [BASE_W-1:0] csr_data
);

   localparam logic [POS_W-1:0] LEN_FULL = POS_W'(MAX_LEN);

   logic [HASH_W-1:0] ph_mem [0:MAX_LEN];
   logic [HASH_W-1:0] pw_mem [0:MAX_LEN];

   state_type         state_ff, state_in;
   logic [POS_W-1:0]  len_ff, len_in;
   logic [BASE_W-1:0] base_ff;
   logic [1:0]        func_ff, func_in;
   logic [7:0]        ch_ff, ch_in;
   logic [POS_W-1:0]  l_ff, l_in, r_ff, r_in;
   logic [POS_W-1:0]  lo_ff, lo_in, hi_ff, hi_in;
   logic              second_ff, second_in;
   logic [POS_W-1:0]  ok_ff, ok_in, ng_ff, ng_in, md_ff, md_in;
   logic [HASH_W-1:0] h1_ff, h1_in, phr_ff, phr_in, pwd_ff, pwd_in;
   logic [HASH_W-1:0] pwh_ff, pwh_in, t_ff, t_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [HASH_W-1:0] rsp_hash_ff, rsp_hash_in;
   logic [POS_W-1:0]  rsp_plen_ff, rsp_plen_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;

   logic [POS_W-1:0]  ph_raddr, pw_raddr, wr_addr;
   logic              mem_we;
   logic [HASH_W-1:0] ph_wdata, pw_wdata;
   logic [HASH_W-1:0] ph_rd_ff, pw_rd_ff;
   logic              ph_zero_ff, pw_zero_ff;
   logic [HASH_W-1:0] ph_eff, pw_eff;

   logic              mul_start, mul_done;
   logic [HASH_W-1:0] mul_a, mul_b, mul_p;

   logic              accept;
   logic [POS_W-1:0]  ra, rb;
   logic [POS_W:0]    md_sum;
   logic [HASH_W-1:0] rh;

   rhse_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   assign ph_eff = ph_zero_ff ? '0 : ph_rd_ff;
   assign pw_eff = pw_zero_ff ? HASH_W'(1) : pw_rd_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ph_mem[wr_addr] <= ph_wdata;
         pw_mem[wr_addr] <= pw_wdata;
      end
      ph_rd_ff   <= ph_mem[ph_raddr];
      pw_rd_ff   <= pw_mem[pw_raddr];
      ph_zero_ff <= (ph_raddr == '0);
      pw_zero_ff <= (pw_raddr == '0);
   end

   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      func_in       = func_ff;
      ch_in         = ch_ff;
      l_in          = l_ff;
      r_in          = r_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      second_in     = second_ff;
      ok_in         = ok_ff;
      ng_in         = ng_ff;
      md_in         = md_ff;
      h1_in         = h1_ff;
      phr_in        = phr_ff;
      pwd_in        = pwd_ff;
      pwh_in        = pwh_ff;
      t_in          = t_ff;
      rsp_valid_in  = 1'b0;
      rsp_hash_in   = rsp_hash_ff;
      rsp_plen_in   = rsp_plen_ff;
      rsp_status_in = rsp_status_ff;
      ph_raddr      = '0;
      pw_raddr      = '0;
      wr_addr       = len_ff + POS_W'(1);
      mem_we        = 1'b0;
      ph_wdata      = t_ff;
      pw_wdata      = mul_p;
      mul_start     = 1'b0;
      mul_a         = pwd_ff;
      mul_b         = ph_eff;
      ra            = len_ff - req_left_pos;
      rb            = len_ff - req_right_pos;
      md_sum        = {1'b0, ok_ff} + {1'b0, ng_ff};
      rh            = mod_sub(phr_ff, mul_p);

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in       = req_func;
               ch_in         = req_char_value;
               l_in          = req_left_pos;
               r_in          = req_right_pos;
               rsp_hash_in   = '0;
               rsp_plen_in   = '0;
               rsp_status_in = ST_OK;
               unique case (req_func)
                  FUNC_APPEND: begin
                     if (len_ff == LEN_FULL) begin
                        rsp_status_in = ST_FULL;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        state_in = S_APP_RD;
                     end
                  end
                  FUNC_HASH: begin
                     if (req_left_pos > req_right_pos || req_right_pos > len_ff) begin
                        rsp_status_in = ST_RANGE;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        lo_in    = req_left_pos;
                        hi_in    = req_right_pos;
                        state_in = S_RH_RD1;
                     end
                  end
                  FUNC_LCP: begin
                     if (req_left_pos > len_ff || req_right_pos > len_ff) begin
                        rsp_status_in = ST_RANGE;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        ok_in    = '0;
                        ng_in    = ((ra < rb) ? ra : rb) + POS_W'(1);
                        state_in = S_LCP_CHK;
                     end
                  end
                  default: begin
                     len_in       = '0;
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_APP_RD: begin
            ph_raddr = len_ff;
            pw_raddr = len_ff;
            state_in = S_APP_MUL1;
         end
         S_APP_MUL1: begin
            pwh_in    = pw_eff;
            mul_a     = ph_eff;
            mul_b     = {{(HASH_W-BASE_W){1'b0}}, base_ff};
            mul_start = 1'b1;
            state_in  = S_APP_W1;
         end
         S_APP_W1: begin
            if (mul_done) begin
               t_in      = mod_add(mul_p, {{(HASH_W-8){1'b0}}, ch_ff});
               mul_a     = pwh_ff;
               mul_b     = {{(HASH_W-BASE_W){1'b0}}, base_ff};
               mul_start = 1'b1;
               state_in  = S_APP_W2;
            end
         end
         S_APP_W2: begin
            if (mul_done) begin
               mem_we        = 1'b1;
               len_in        = len_ff + POS_W'(1);
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_RH_RD1: begin
            ph_raddr = hi_ff;
            pw_raddr = hi_ff - lo_ff;
            state_in = S_RH_RD2;
         end
         S_RH_RD2: begin
            phr_in   = ph_eff;
            pwd_in   = pw_eff;
            ph_raddr = lo_ff;
            state_in = S_RH_MUL;
         end
         S_RH_MUL: begin
            mul_a     = pwd_ff;
            mul_b     = ph_eff;
            mul_start = 1'b1;
            state_in  = S_RH_WAIT;
         end
         S_RH_WAIT: begin
            if (mul_done) begin
               if (func_ff == FUNC_HASH) begin
                  rsp_hash_in  = rh;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else if (!second_ff) begin
                  h1_in     = rh;
                  lo_in     = r_ff;
                  hi_in     = r_ff + md_ff;
                  second_in = 1'b1;
                  state_in  = S_RH_RD1;
               end else begin
                  if (rh == h1_ff) begin
                     ok_in = md_ff;
                  end else begin
                     ng_in = md_ff;
                  end
                  state_in = S_LCP_CHK;
               end
            end
         end
         S_LCP_CHK: begin
            if (ng_ff - ok_ff > POS_W'(1)) begin
               md_in     = md_sum[POS_W:1];
               lo_in     = l_ff;
               hi_in     = l_ff + md_sum[POS_W:1];
               second_in = 1'b0;
               state_in  = S_RH_RD1;
            end else begin
               rsp_plen_in  = ok_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         base_ff      <= BASE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            base_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      ch_ff         <= ch_in;
      l_ff          <= l_in;
      r_ff          <= r_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      second_ff     <= second_in;
      ok_ff         <= ok_in;
      ng_ff         <= ng_in;
      md_ff         <= md_in;
      h1_ff         <= h1_in;
      phr_ff        <= phr_in;
      pwd_ff        <= pwd_in;
      pwh_ff        <= pwh_in;
      t_ff          <= t_in;
      rsp_hash_ff   <= rsp_hash_in;
      rsp_plen_ff   <= rsp_plen_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_strobe        = rsp_valid_ff;
   assign rsp_hash_value    = rsp_hash_ff;
   assign rsp_prefix_length = rsp_plen_ff;
   assign rsp_status        = rsp_status_ff;

`ifndef SYNTH
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_FULL)
      else $error("text length beyond capacity");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy || rsp_strobe)
      else $error("accepted request neither in progress nor answered");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != ST_OK |-> rsp_hash_value == '0 && rsp_prefix_length == '0)
      else $error("error result carries data");

   a_mul_done_wait: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == S_APP_W1 || state_ff == S_APP_W2 || state_ff == S_RH_WAIT)
      else $error("multiplier finished outside a wait state");

   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> wr_addr != '0)
      else $error("write to fixed entry zero");
`endif

endmodule

>>> bench/rolling_hash_substring_engine_tb.sv
`timescale 1ns / 1ps

module rolling_hash_substring_engine_tb;
   import rhse_pkg::*;

   typedef struct packed {
      logic [HASH_W-1:0] hash_value;
      logic [POS_W-1:0]  prefix_length;
      logic [1:0]        status;
   } result_type;

   localparam int unsigned WATCHDOG_LIMIT = 20000;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [1:0]        req_func;
   logic [7:0]        req_char_value;
   logic [POS_W-1:0]  req_left_pos;
   logic [POS_W-1:0]  req_right_pos;
   logic              rsp_strobe;
   logic [HASH_W-1:0] rsp_hash_value;
   logic [POS_W-1:0]  rsp_prefix_length;
   logic [1:0]        rsp_status;
   logic              csr_valid;
   logic              csr_ready;
   logic [BASE_W-1:0] csr_data;

   logic [HASH_W-1:0] model_prefix [0:MAX_LEN];
   logic [HASH_W-1:0] model_power [0:MAX_LEN];
   int unsigned       model_len;
   logic [BASE_W-1:0] model_base;

   result_type  expected_results [$];
   int unsigned error_count;
   int unsigned idle_cycles;
   int unsigned send_idle_pct;

   rolling_hash_substring_engine u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_char_value(req_char_value),
      .req_left_pos(req_left_pos), .req_right_pos(req_right_pos),
      .rsp_strobe(rsp_strobe), .rsp_hash_value(rsp_hash_value),
      .rsp_prefix_length(rsp_prefix_length), .rsp_status(rsp_status),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [HASH_W-1:0] mul_mod(input logic [HASH_W-1:0] a,
                                                 input logic [HASH_W-1:0] b);
      logic [2*HASH_W-1:0] p;
      logic [HASH_W+1:0]   s;
      p = a * b;
      s = p[HASH_W-1:0] + p[2*HASH_W-1:HASH_W];
      s = s[HASH_W-1:0] + s[HASH_W+1:HASH_W];
      if (s >= MOD61) s = s - MOD61;
      return s[HASH_W-1:0];
   endfunction

   function automatic logic [HASH_W-1:0] sum_mod(input logic [HASH_W-1:0] a,
                                                 input logic [HASH_W-1:0] b);
      logic [HASH_W:0] s;
      s = a + b;
      if (s >= MOD61) s = s - MOD61;
      return s[HASH_W-1:0];
   endfunction

   function automatic logic [HASH_W-1:0] span_hash(input int unsigned l,
                                                   input int unsigned r);
      logic [HASH_W-1:0] t;
      t = mul_mod(model_power[POS_W'(r-l)], model_prefix[POS_W'(l)]);
      return sum_mod(model_prefix[POS_W'(r)], MOD61 - t);
   endfunction

   function automatic result_type predict_request(input logic [1:0] f,
                                                  input logic [7:0] ch,
                                                  input int unsigned l,
                                                  input int unsigned r);
      result_type  res;
      int unsigned lo, hi, md, ra, rb;
      res = '0;
      case (f)
         FUNC_APPEND: begin
            if (model_len >= MAX_LEN) res.status = ST_FULL;
            else begin
               model_prefix[POS_W'(model_len+1)] =
                  sum_mod(mul_mod(model_prefix[POS_W'(model_len)], HASH_W'(model_base)),
                          HASH_W'(ch));
               model_power[POS_W'(model_len+1)] =
                  mul_mod(model_power[POS_W'(model_len)], HASH_W'(model_base));
               model_len++;
            end
         end
         FUNC_HASH: begin
            if (l > r || r > model_len) res.status = ST_RANGE;
            else res.hash_value = span_hash(l, r);
         end
         FUNC_LCP: begin
            if (l > model_len || r > model_len) res.status = ST_RANGE;
            else begin
               ra = model_len - l;
               rb = model_len - r;
               lo = 0;
               hi = (ra < rb ? ra : rb) + 1;
               while (hi - lo > 1) begin
                  md = (lo + hi) >> 1;
                  if (span_hash(l, l + md) == span_hash(r, r + md)) lo = md;
                  else hi = md;
               end
               res.prefix_length = POS_W'(lo);
            end
         end
         default: model_len = 0;
      endcase
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch @%0t: %s", $time, msg);
      error_count++;
   endtask

   always @(posedge clock) begin
      result_type e;
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0) report_mismatch("unexpected result");
         else begin
            e = expected_results.pop_front();
            if (rsp_hash_value !== e.hash_value)
               report_mismatch($sformatf("hash %h exp %h", rsp_hash_value, e.hash_value));
            if (rsp_prefix_length !== e.prefix_length)
               report_mismatch($sformatf("prefix %0d exp %0d", rsp_prefix_length,
                                         e.prefix_length));
            if (rsp_status !== e.status)
               report_mismatch($sformatf("status %0d exp %0d", rsp_status, e.status));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // start stays high after the request is taken; an idle cycle in the next
   // call or a drain drops it
   task automatic send_request(input logic [1:0] f, input logic [7:0] ch,
                               input int unsigned l, input int unsigned r);
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_func       <= f;
      req_char_value <= ch;
      req_left_pos   <= POS_W'(l);
      req_right_pos  <= POS_W'(r);
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_results.push_back(predict_request(f, ch, l, r));
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_base(input logic [BASE_W-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      model_base = value;
      csr_valid <= 1'b0;
   endtask

   task automatic append_text(input int unsigned n, input int unsigned alphabet);
      repeat (n) send_request(FUNC_APPEND, 8'($urandom_range(alphabet - 1)), 0, 0);
   endtask

   task automatic test_directed();
      send_request(FUNC_HASH, 0, 0, 0);
      send_request(FUNC_LCP, 0, 0, 0);
      send_request(FUNC_HASH, 0, 0, 1);
      send_request(FUNC_LCP, 0, 8191, 0);
      send_request(FUNC_APPEND, 8'hFF, 0, 0);
      send_request(FUNC_APPEND, 8'h00, 0, 0);
      send_request(FUNC_APPEND, 8'hFF, 0, 0);
      send_request(FUNC_APPEND, 8'h00, 0, 0);
      send_request(FUNC_HASH, 0, 0, 4);
      send_request(FUNC_HASH, 0, 2, 1);
      send_request(FUNC_HASH, 0, 4, 4);
      send_request(FUNC_HASH, 0, 8191, 8191);
      send_request(FUNC_LCP, 0, 0, 2);
      send_request(FUNC_LCP, 0, 1, 1);
      send_request(FUNC_LCP, 0, 4, 0);
      send_request(FUNC_LCP, 0, 0, 5);
      send_request(FUNC_CLEAR, 8'hA5, 8191, 8191);
      send_request(FUNC_HASH, 0, 0, 1);
   endtask

   task automatic test_base_change();
      write_base(32'hFFFF_FFFF);
      append_text(6, 256);
      write_base(32'd0);
      append_text(4, 256);
      write_base(32'd1);
      append_text(4, 2);
      send_request(FUNC_HASH, 0, 0, 14);
      send_request(FUNC_LCP, 0, 2, 9);
      send_request(FUNC_LCP, 0, 10, 12);
      send_request(FUNC_CLEAR, 0, 0, 0);
   endtask

   task automatic test_random(input int unsigned n);
      int unsigned k, l, r, sel;
      for (k = 0; k < n; k++) begin
         if (k % 150 == 0) begin
            send_request(FUNC_CLEAR, 8'($urandom), 13'($urandom), 13'($urandom));
            append_text($urandom_range(40, 8), $urandom_range(1, 0) ? 2 : 256);
            if ($urandom_range(1)) begin
               // repeat the text so long common prefixes show up
               for (l = 0; l < 12 && model_len < MAX_LEN; l++)
                  send_request(FUNC_APPEND, 8'(sum_mod(model_prefix[POS_W'(l+1)],
                     MOD61 - mul_mod(model_prefix[POS_W'(l)], HASH_W'(model_base)))),
                     0, 0);
            end
         end
         sel = $urandom_range(99);
         l = $urandom_range(model_len);
         r = $urandom_range(model_len);
         if (sel < 20) send_request(FUNC_APPEND, 8'($urandom), 13'($urandom), 13'($urandom));
         else if (sel < 50)
            send_request(FUNC_HASH, 8'($urandom), l < r ? l : r, l < r ? r : l);
         else if (sel < 85) send_request(FUNC_LCP, 8'($urandom), l, r);
         else if (sel < 97)
            send_request($urandom_range(1) ? FUNC_HASH : FUNC_LCP, 8'($urandom),
                         13'($urandom), 13'($urandom));
         else send_request(FUNC_CLEAR, 8'($urandom), 13'($urandom), 13'($urandom));
         if (k == n / 2) wait_drained();
      end
   endtask

   initial begin
      error_count    = 0;
      idle_cycles    = 0;
      send_idle_pct  = 24;
      model_len      = 0;
      model_base     = BASE_RESET;
      model_prefix[0] = '0;
      model_power[0]  = HASH_W'(1);
      reset          = 1'b1;
      start          = 1'b0;
      req_func       = FUNC_CLEAR;
      req_char_value = '0;
      req_left_pos   = '0;
      req_right_pos  = '0;
      csr_valid      = 1'b0;
      csr_data       = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_base_change();
      write_base(32'd131);
      test_random(270);
      send_idle_pct = 77;
      write_base($urandom);
      test_random(270);
      send_idle_pct = 0;
      write_base(32'd2);
      test_random(270);
      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

>>> files.f
rtl/core/rhse_pkg.sv
rtl/core/rhse_mulmod.sv
rtl/core/rolling_hash_substring_engine.sv
bench/rolling_hash_substring_engine_tb.sv
